// ===== design/scdm_pkg.sv =====
// ----------------------------------------------------------------------------
// scdm_pkg
// Types, widths and helpers shared by the stereo compensation delay blocks.
// ----------------------------------------------------------------------------
package scdm_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int DELAY_W     = 14;
  localparam int CFG_DATA_W  = 16;

  // Ring store depth; must be a power of two (read address and delay wrap by mask).
  localparam int STORE_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Q1.15 gain arithmetic
  localparam int SHIFT  = 15;
  localparam int PROD_W = GAIN_W + 1 + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(2 ** (SHIFT - 1));

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample_a;
    sample_t sample_b;
  } in_item_t;

  typedef struct packed {
    sample_t mixed_a;
    sample_t mixed_b;
  } out_item_t;

  // per-item lane control, carried alongside stage one
  typedef struct packed {
    logic fwd;  // read address equals write address: take the incoming sample
    logic hit;  // read entry has been written since reset
  } lane_ctl_t;

  typedef enum logic [1:0] {
    REG_DELAY,
    REG_DRY,
    REG_WET,
    REG_BYPASS
  } cfg_reg_t;

  // floor shift by SHIFT then clamp to the sample range
  function automatic sample_t sat_sample(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-SHIFT-1:0] sh;
    logic [ACC_W-SHIFT-SAMPLE_W:0] top;
    sh  = acc[ACC_W-1:SHIFT];
    top = sh[ACC_W-SHIFT-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      sat_sample = sh[SAMPLE_W-1:0];
    end else if (top[ACC_W-SHIFT-SAMPLE_W]) begin
      sat_sample = SAMPLE_MIN;
    end else begin
      sat_sample = SAMPLE_MAX;
    end
  endfunction

endpackage

// ===== design/scdm_ram.sv =====
// ----------------------------------------------------------------------------
// scdm_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module scdm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/scdm_lane.sv =====
// ----------------------------------------------------------------------------
// scdm_lane
// One channel: ring store, delayed-sample select and the two gain products.
// ----------------------------------------------------------------------------
module scdm_lane
  import scdm_pkg::*;
(
  input  logic              clk,
  input  logic              en1,
  input  logic              en2,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ADDR_W-1:0] rd_addr,
  input  sample_t           x,
  input  lane_ctl_t         ctl1,
  input  logic [GAIN_W-1:0] dry_gain,
  input  logic [GAIN_W-1:0] wet_gain,
  output sample_t           x2,
  output sample_t           mix
);

  logic [SAMPLE_W-1:0]      rd_data;
  sample_t                  x1;
  sample_t                  delayed;
  logic signed [PROD_W-1:0] p_dry;
  logic signed [PROD_W-1:0] p_wet;
  logic signed [ACC_W-1:0]  acc;

  scdm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (x),
    .rd_en   (en1),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // unwritten entries read as zero; zero delay forwards the sample just written
  always_comb begin
    if (ctl1.fwd) begin
      delayed = x1;
    end else if (ctl1.hit) begin
      delayed = rd_data;
    end else begin
      delayed = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      x1 <= x;
    end
    if (en2) begin
      p_dry <= $signed({1'b0, dry_gain}) * x1;
      p_wet <= $signed({1'b0, wet_gain}) * delayed;
      x2    <= x1;
    end
  end

  assign acc = $signed({p_dry[PROD_W-1], p_dry}) + $signed({p_wet[PROD_W-1], p_wet}) + ROUND;
  assign mix = sat_sample(acc);

endmodule

// ===== design/scdm_merge.sv =====
// ----------------------------------------------------------------------------
// scdm_merge
// Output register: joins both lanes into one result, bypass select.
// ----------------------------------------------------------------------------
module scdm_merge
  import scdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en3,
  input  logic      v2,
  input  logic      byp2,
  input  sample_t   mix_a,
  input  sample_t   x_a,
  input  sample_t   mix_b,
  input  sample_t   x_b,
  output logic      out_valid,
  output out_item_t out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
    if (en3) begin
      out_data.mixed_a <= byp2 ? x_a : mix_a;
      out_data.mixed_b <= byp2 ? x_b : mix_b;
    end
  end

endmodule

// ===== design/stereo_compensation_delay_mix.sv =====
// ----------------------------------------------------------------------------
// stereo_compensation_delay_mix
// Stages: input register and store read, gain products, output register.
// Throughput: one stereo transaction per cycle unless stalled; each lane's store
// takes one write and one read per cycle, and every stage can stall on its own.
// Reset: control and registers return to defaults; the stores are not swept,
// a fill flag makes never-written entries read as zero, so no clearing pass.
// ----------------------------------------------------------------------------
module stereo_compensation_delay_mix
  import scdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_reg_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [DELAY_W-1:0] delay_samples;
  logic [GAIN_W-1:0]  dry_gain;
  logic [GAIN_W-1:0]  wet_gain;
  logic               bypass;

  // ring pointer and fill tracking
  logic [ADDR_W-1:0]  write_pos;
  logic [ADDR_W-1:0]  write_pos_next;
  logic               wrapped;
  logic [ADDR_W-1:0]  delay_mod;
  logic [ADDR_W-1:0]  rd_addr;

  // pipeline control
  logic               v1, v2;
  logic               byp1, byp2;
  lane_ctl_t          ctl1;
  logic               en1, en2, en3;
  logic               accept;

  sample_t            x2_a, x2_b, mix_a, mix_b;

  // Each stage moves on when the one after it is empty or moving, so bubbles
  // collapse and a new transaction is taken while a result waits at the output.
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign accept   = in_valid && en1;

  assign cfg_ready = 1'b1;

  // Depth is a power of two: delay wraps by mask, read address by modular subtract.
  assign delay_mod = ADDR_W'(delay_samples % STORE_DEPTH);
  assign rd_addr   = write_pos - delay_mod;

  assign write_pos_next = (write_pos == ADDR_W'(STORE_DEPTH - 1)) ? '0 : write_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      dry_gain      <= '0;
      wet_gain      <= GAIN_W'(32768);
      bypass        <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY:  delay_samples <= cfg_data[DELAY_W-1:0];
        REG_DRY:    dry_gain      <= cfg_data[GAIN_W-1:0];
        REG_WET:    wet_gain      <= cfg_data[GAIN_W-1:0];
        REG_BYPASS: bypass        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Writes run 0,1,2,... so before the first wrap only entries at or below
  // the write pointer hold data; after it every entry does.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      wrapped   <= 1'b0;
    end else if (accept) begin
      write_pos <= write_pos_next;
      if (write_pos == ADDR_W'(STORE_DEPTH - 1)) begin
        wrapped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
    if (en1) begin
      // zero delay reads the entry being written this cycle: forward instead
      ctl1.fwd <= (delay_mod == '0);
      ctl1.hit <= wrapped || (rd_addr <= write_pos);
      byp1     <= bypass;
    end
    if (en2) begin
      byp2 <= byp1;
    end
  end

  scdm_lane u_lane_a (
    .clk      (clk),
    .en1      (en1),
    .en2      (en2),
    .wr_en    (accept),
    .wr_addr  (write_pos),
    .rd_addr  (rd_addr),
    .x        (in_data.sample_a),
    .ctl1     (ctl1),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .x2       (x2_a),
    .mix      (mix_a)
  );

  scdm_lane u_lane_b (
    .clk      (clk),
    .en1      (en1),
    .en2      (en2),
    .wr_en    (accept),
    .wr_addr  (write_pos),
    .rd_addr  (rd_addr),
    .x        (in_data.sample_b),
    .ctl1     (ctl1),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .x2       (x2_b),
    .mix      (mix_b)
  );

  // final stage: saturated mixes or raw inputs into the output register
  scdm_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en3       (en3),
    .v2        (v2),
    .byp2      (byp2),
    .mix_a     (mix_a),
    .x_a       (x2_a),
    .mix_b     (mix_b),
    .x_b       (x2_b),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== design/scdm_checker.sv =====
// ----------------------------------------------------------------------------
// scdm_checker
// Port-level checks on the stereo compensation delay mix, bound to the top.
// ----------------------------------------------------------------------------
module scdm_checker
  import scdm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_item_t             out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // pipeline empty straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> !out_valid)
    else $error("result valid right after reset");

  // input only stalls when the output is backed up
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

  // with the output draining, an accepted transaction reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result late");

endmodule

bind stereo_compensation_delay_mix scdm_checker u_scdm_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks stereo_compensation_delay_mix against a cycle-free model of the ring
// store and the Q1.15 dry/wet mix. Items are fed through a clocked driver and
// results are checked in order by a clocked monitor, with random idling on
// both channels and register writes only while the block is drained.
// ----------------------------------------------------------------------------
module testbench;
  import scdm_pkg::*;

  localparam longint MIX_MAX = 8388607;
  localparam longint MIX_MIN = -8388608;
  localparam int SEG_ITEMS = 150;

  typedef struct {
    cfg_reg_t              idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // DUT ports; every input is known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = REG_DELAY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and expectation queues
  in_item_t   pending_q[$];
  reg_write_t reg_write_q[$];
  out_item_t  expected_mix_q[$];

  // Model state: ring stores, write pointer and the four registers
  sample_t             ring_a [STORE_DEPTH];
  sample_t             ring_b [STORE_DEPTH];
  logic [ADDR_W-1:0]   wr_ptr = '0;
  logic [DELAY_W-1:0]  delay_m = '0;
  logic [GAIN_W-1:0]   dry_m = '0;
  logic [GAIN_W-1:0]   wet_m = 16'd32768;
  logic                bypass_m = 1'b0;

  int mismatch_count = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 54;
  int fed_count = 0;

  stereo_compensation_delay_mix dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------

  // Q1.15 mix with round-half-up, floor shift, then clamp to 24 bits.
  function automatic sample_t mix_lane(sample_t x, sample_t dly);
    longint acc;
    longint q;
    acc = longint'(dry_m) * longint'(x) + longint'(wet_m) * longint'(dly) + 64'sd16384;
    q   = acc >>> SHIFT;
    if (q > MIX_MAX) q = MIX_MAX;
    if (q < MIX_MIN) q = MIX_MIN;
    return sample_t'(q);
  endfunction

  // Write first, then read: a zero delay gives back the sample just stored.
  // The depth is a power of two, so the read address wraps by truncation.
  function automatic out_item_t delay_and_mix(in_item_t it);
    out_item_t         res;
    logic [ADDR_W-1:0] rd;
    ring_a[wr_ptr] = it.sample_a;
    ring_b[wr_ptr] = it.sample_b;
    rd = wr_ptr - ADDR_W'(delay_m);
    if (bypass_m) begin
      res.mixed_a = it.sample_a;
      res.mixed_b = it.sample_b;
    end else begin
      res.mixed_a = mix_lane(it.sample_a, ring_a[rd]);
      res.mixed_b = mix_lane(it.sample_b, ring_b[rd]);
    end
    wr_ptr = wr_ptr + 1'b1;
    return res;
  endfunction

  function automatic void latch_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_DELAY:  delay_m = d[DELAY_W-1:0];
      REG_DRY:    dry_m = d[GAIN_W-1:0];
      REG_WET:    wet_m = d[GAIN_W-1:0];
      REG_BYPASS: bypass_m = d[0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: input and register channels. The model is updated on the edge at
  // which a transaction is accepted, so its order matches the block's.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_mix_q.push_back(delay_and_mix(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end

      if (cfg_valid && cfg_ready) begin
        latch_register(cfg_index, cfg_data);
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_write_q.size() != 0) begin
          reg_write_t w;
          w = reg_write_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data  <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure and in-order field compare
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        if (expected_mix_q.size() == 0) begin
          $display("%0t: unexpected result a=%0d b=%0d", $time,
                   out_data.mixed_a, out_data.mixed_b);
          mismatch_count++;
        end else begin
          out_item_t exp_item;
          exp_item = expected_mix_q.pop_front();
          if (out_data.mixed_a !== exp_item.mixed_a) begin
            $display("%0t: mixed_a expected %0d got %0d", $time,
                     exp_item.mixed_a, out_data.mixed_a);
            mismatch_count++;
          end
          if (out_data.mixed_b !== exp_item.mixed_b) begin
            $display("%0t: mixed_b expected %0d got %0d", $time,
                     exp_item.mixed_b, out_data.mixed_b);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (run on the falling edge, clear of the drivers)
  // --------------------------------------------------------------------------

  // Block is drained: nothing queued, nothing on either channel, nothing owed.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || reg_write_q.size() != 0 || cfg_valid ||
           expected_mix_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_stereo(sample_t a, sample_t b);
    in_item_t it;
    it.sample_a = a;
    it.sample_b = b;
    pending_q.push_back(it);
    fed_count++;
  endtask

  task automatic queue_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    reg_write_t w;
    w.idx  = idx;
    w.data = d;
    reg_write_q.push_back(w);
  endtask

  // Full scale and near-zero values turn up often; the rest is uniform.
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return sample_t'(SAMPLE_MAX);
      1: return sample_t'(SAMPLE_MIN);
      2: return '0;
      3: return '1;
      4: return sample_t'($urandom_range(511)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(6))
      0: return '0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      3: return 16'd1;
      4: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(32768));
    endcase
  endfunction

  // Mostly delays that land on samples already stored; sometimes the far end
  // of the ring, which reads entries still at their reset value.
  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    logic [DELAY_W-1:0] d;
    case ($urandom_range(7))
      0: d = '0;
      1: d = 14'd1;
      2: d = '1;
      3: d = DELAY_W'($urandom);
      4, 5: d = DELAY_W'($urandom_range(32));
      default: d = DELAY_W'($urandom_range(fed_count));
    endcase
    // upper bits of the write data are outside the register and must be dropped
    return {(CFG_DATA_W - DELAY_W)'($urandom), d};
  endfunction

  task automatic program_random_setting();
    queue_reg(REG_DELAY, pick_delay());
    queue_reg(REG_DRY, pick_gain());
    queue_reg(REG_WET, pick_gain());
    queue_reg(REG_BYPASS, {(CFG_DATA_W - 1)'($urandom), ($urandom_range(4) == 0)});
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (ring_a[i]) begin
      ring_a[i] = '0;
      ring_b[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero delay, unity wet, no dry, so output follows input.
    queue_stereo(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    queue_stereo(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    queue_stereo('0, '1);
    queue_stereo(sample_t'(1), '1);
    wait_drained();

    // Unity dry plus unity wet at a short delay: saturates both ways.
    queue_reg(REG_DELAY, 16'hC002);
    queue_reg(REG_DRY, 16'd32768);
    queue_reg(REG_WET, 16'd32768);
    queue_reg(REG_BYPASS, 16'h0000);
    wait_drained();
    repeat (4) queue_stereo(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    queue_stereo(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    wait_drained();

    // Largest delay reads an entry never written; gains just under two.
    queue_reg(REG_DELAY, 16'hFFFF);
    queue_reg(REG_DRY, 16'hFFFF);
    queue_reg(REG_WET, 16'hFFFF);
    wait_drained();
    queue_stereo(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    queue_stereo('0, '0);
    queue_stereo(sample_t'(12345), sample_t'(-12345));
    wait_drained();

    // Wet only, above unity, reading back stored samples.
    queue_reg(REG_DELAY, 16'd5);
    queue_reg(REG_DRY, 16'd0);
    wait_drained();
    queue_stereo(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    queue_stereo(sample_t'(1), '1);
    queue_stereo(sample_t'(SAMPLE_MAX), '0);
    wait_drained();

    // Bypass: input passes straight through, store still advancing.
    queue_reg(REG_BYPASS, 16'hFFFF);
    queue_reg(REG_DRY, 16'd1);
    queue_reg(REG_WET, 16'd0);
    wait_drained();
    queue_stereo(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    queue_stereo('1, '0);
    queue_stereo(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    wait_drained();

    // Bypass off again with both gains zero: silence.
    queue_reg(REG_BYPASS, 16'hFFFE);
    queue_reg(REG_DRY, 16'd0);
    wait_drained();
    queue_stereo(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    queue_stereo(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    wait_drained();

    // Random part in three idling phases; each segment drains fully before the
    // next setting, which also gives the sender a long pause.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 7;  recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        program_random_setting();
        repeat (SEG_ITEMS) queue_stereo(pick_sample(), pick_sample());
        wait_drained();
      end
    end

    // spare cycles at the end catch anything stray
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
